FILE: src/fac_pkg.sv
// Shared types and constants for the fully associative FIFO cache tag block.
// Used by the RTL, the checker and the testbench; depends on nothing.
package fac_pkg;

  parameter int CACHE_WORDS = 256;
  parameter int ADDR_BITS   = 32;

  parameter int LSZ_W   = 3;
  parameter int WORD_W  = 1 << LSZ_W;
  parameter int CNT_W   = 32;
  parameter int NUM_CNT = 6;

  parameter int C_RH    = 0;
  parameter int C_RM    = 1;
  parameter int C_WH    = 2;
  parameter int C_WM    = 3;
  parameter int C_FETCH = 4;
  parameter int C_WBACK = 5;

  typedef struct packed {
    logic clear;
    logic access;
    logic hit;
    logic is_write;
    logic evict;
  } stat_upd_t;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_bank_t;

endpackage

FILE: src/fully_assoc_fifo_cache_tags_top.sv
// Top level of the fully associative write-back cache tag model with FIFO replacement.
// Depends on fac_pkg, fac_ram (tag store) and fac_stats (statistics counters).
//
// Usage: each input transaction on s_* carries a command and, for an access, the
// read/write flag and word address. A clear command empties the store, resets the
// FIFO pointer and zeroes all counters. Every input transaction yields exactly one
// output transaction on m_* with the hit and dirty-eviction flags and the six
// running counters. The cfg channel sets log2 of the words per line; write it only
// while the block is idle.
// An access scans the tag RAM one line per cycle through its single read port, over
// lines = CACHE_WORDS >> line_size_log2 lines (at least one), before its result goes
// to the output register. A hit ends the scan early; a clear skips the scan. The
// next transaction can be accepted in the cycle after the result is loaded.
// s_tready is high only while the sequencer is idle. The result sits in an output
// register; the block accepts the next transaction while it waits, but does not load
// a new result until the receiver has taken the old one.
// Reset clears the line valid and dirty bits, the FIFO pointer, the counters and the
// line size register. The tag RAM needs no clearing pass.
module fully_assoc_fifo_cache_tags_top #(
  parameter int CACHE_WORDS = fac_pkg::CACHE_WORDS,
  parameter int ADDR_BITS   = fac_pkg::ADDR_BITS,
  localparam int IN_DATA_W  = ((ADDR_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = fac_pkg::NUM_CNT * fac_pkg::CNT_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_DATA_W-1:0]      s_tdata,   // address
  input  logic [1:0]                s_tuser,   // command, is_write
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_W-1:0]     m_tdata,   // read_hits, read_misses, write_hits,
                                               // write_misses, words_fetched,
                                               // words_written_back
  output logic [1:0]                m_tuser,   // hit, dirty_evict
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fac_pkg::LSZ_W-1:0] cfg_data   // line_size_log2
);

  localparam int LINE_IDX_W = $clog2(CACHE_WORDS);
  localparam int LINE_CNT_W = $clog2(CACHE_WORDS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                  state;
  logic [fac_pkg::LSZ_W-1:0]   line_size;
  logic [ADDR_BITS-1:0]        tag;
  logic                        wr;
  logic [LINE_CNT_W-1:0]       scan_idx;
  logic [LINE_IDX_W-1:0]       cmp_idx;
  logic                        cmp_pend;
  logic [LINE_IDX_W-1:0]       fifo_ptr;
  logic                        hit;
  logic                        evict;
  logic [CACHE_WORDS-1:0]      line_valid;
  logic [CACHE_WORDS-1:0]      line_dirty;

  logic [LINE_CNT_W-1:0]       lines_raw;
  logic [LINE_CNT_W-1:0]       num_lines;
  logic                        issue;
  logic                        match;
  logic                        miss_go;
  logic [LINE_IDX_W-1:0]       victim;
  logic [LINE_CNT_W-1:0]       ptr_inc;
  logic [LINE_IDX_W-1:0]       ptr_next;
  logic                        victim_dirty;
  logic                        in_fire;
  logic                        out_load;
  logic [ADDR_BITS-1:0]        ram_rdata;
  logic                        ram_we;
  logic [fac_pkg::WORD_W-1:0]  words;
  fac_pkg::stat_upd_t          upd;
  fac_pkg::cnt_bank_t          cnt;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_load  = (state == ST_FIN) && (!m_tvalid || m_tready);

  assign lines_raw = LINE_CNT_W'(CACHE_WORDS) >> line_size;
  assign num_lines = (lines_raw == '0) ? LINE_CNT_W'(1) : lines_raw;
  assign issue     = scan_idx < num_lines;
  assign match     = cmp_pend && line_valid[cmp_idx] && (ram_rdata == tag);
  assign miss_go   = !issue && !match;

  assign victim       = (LINE_CNT_W'(fifo_ptr) < num_lines) ? fifo_ptr : '0;
  assign ptr_inc      = LINE_CNT_W'(victim) + LINE_CNT_W'(1);
  assign ptr_next     = (ptr_inc >= num_lines) ? '0 : ptr_inc[LINE_IDX_W-1:0];
  assign victim_dirty = line_valid[victim] && line_dirty[victim];
  assign words        = fac_pkg::WORD_W'(1) << line_size;
  assign ram_we       = (state == ST_SCAN) && miss_go;

  always_comb begin
    upd          = '0;
    upd.clear    = in_fire && s_tuser[0];
    upd.access   = (state == ST_SCAN) && (match || miss_go);
    upd.hit      = match;
    upd.is_write = wr;
    upd.evict    = victim_dirty;
  end

  fac_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (CACHE_WORDS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (victim),
    .wdata (tag),
    .raddr (scan_idx[LINE_IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  fac_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .words (words),
    .cnt   (cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      line_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fifo_ptr   <= '0;
      line_valid <= '0;
      line_dirty <= '0;
      cmp_pend   <= 1'b0;
      scan_idx   <= '0;
      hit        <= 1'b0;
      evict      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            tag      <= s_tdata[ADDR_BITS-1:0] >> line_size;
            wr       <= s_tuser[1];
            scan_idx <= '0;
            cmp_pend <= 1'b0;
            hit      <= 1'b0;
            evict    <= 1'b0;
            if (s_tuser[0]) begin
              line_valid <= '0;
              line_dirty <= '0;
              fifo_ptr   <= '0;
              state      <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (match) begin
            hit   <= 1'b1;
            state <= ST_FIN;
            if (wr) begin
              line_dirty[cmp_idx] <= 1'b1;
            end
          end else if (miss_go) begin
            evict              <= victim_dirty;
            line_valid[victim] <= 1'b1;
            line_dirty[victim] <= wr;
            fifo_ptr           <= ptr_next;
            state              <= ST_FIN;
          end else begin
            cmp_idx  <= scan_idx[LINE_IDX_W-1:0];
            cmp_pend <= issue;
            scan_idx <= scan_idx + LINE_CNT_W'(1);
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= cnt;
      m_tuser <= {evict, hit};
    end
  end

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hit and dirty eviction reported together");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser[0]) |=> (line_valid == '0 && line_dirty == '0))
    else $error("clear did not empty the store");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> line_valid[$past(victim)])
    else $error("filled line is not valid");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_idx <= num_lines))
    else $error("tag scan ran past the last line");

endmodule

FILE: src/fac_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/fac_stats.sv
// Six saturating statistics counters of the cache tag block.
// Depends on fac_pkg for the update struct and counter positions.
module fac_stats (
  input  logic                         clk,
  input  logic                         rst,
  input  fac_pkg::stat_upd_t           upd,
  input  logic [fac_pkg::WORD_W-1:0]   words,
  output fac_pkg::cnt_bank_t           cnt
);

  fac_pkg::cnt_bank_t                       cnt_next;
  logic [fac_pkg::NUM_CNT-1:0][fac_pkg::WORD_W-1:0] inc;
  logic [fac_pkg::CNT_W:0]                  sum;

  always_comb begin
    inc = '0;
    if (upd.access) begin
      if (upd.hit) begin
        if (upd.is_write) begin
          inc[fac_pkg::C_WH] = fac_pkg::WORD_W'(1);
        end else begin
          inc[fac_pkg::C_RH] = fac_pkg::WORD_W'(1);
        end
      end else begin
        if (upd.is_write) begin
          inc[fac_pkg::C_WM] = fac_pkg::WORD_W'(1);
        end else begin
          inc[fac_pkg::C_RM] = fac_pkg::WORD_W'(1);
        end
        inc[fac_pkg::C_FETCH] = words;
        if (upd.evict) begin
          inc[fac_pkg::C_WBACK] = words;
        end
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    sum = '0;
    for (int k = 0; k < fac_pkg::NUM_CNT; k++) begin
      sum = {1'b0, cnt[k]} + (fac_pkg::CNT_W + 1)'(inc[k]);
      cnt_next[k] = sum[fac_pkg::CNT_W] ? '1 : sum[fac_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

FILE: sim/fac_tags_checker.sv
`timescale 1ns / 1ps
// Checker for the fully associative FIFO cache tag block: tracks tags, dirty bits and counters.
// Depends on fac_pkg from the RTL; holds fac_tb_pkg with the testbench command codes.
package fac_tb_pkg;

  typedef enum logic {CMD_ACCESS = 1'b0, CMD_CLEAR = 1'b1} cache_cmd_e;
  typedef enum logic {ACC_READ = 1'b0, ACC_WRITE = 1'b1} access_kind_e;

endpackage

module fac_tags_checker
  import fac_pkg::*;
  import fac_tb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [ADDR_BITS-1:0]      s_addr,
  input  logic [1:0]                s_tuser,    // command, is_write
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [NUM_CNT*CNT_W-1:0]  m_tdata,    // read_hits .. words_written_back
  input  logic [1:0]                m_tuser,    // hit, dirty_evict
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [LSZ_W-1:0]          cfg_data,   // line_size_log2
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct packed {
    logic      hit;
    logic      dirty_evict;
    cnt_bank_t counts;
  } cache_result_t;

  logic [ADDR_BITS-1:0] tag_store [CACHE_WORDS];
  bit                   line_valid_q [CACHE_WORDS];
  bit                   line_dirty_q [CACHE_WORDS];
  int unsigned          fifo_ptr;
  cnt_bank_t            stats;
  logic [LSZ_W-1:0]     line_shift;
  cache_result_t        expected_q [$];
  string                cnt_names [NUM_CNT] = '{"read_hits", "read_misses", "write_hits",
                                                "write_misses", "words_fetched",
                                                "words_written_back"};

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < CACHE_WORDS; i++) begin
      line_valid_q[i] = 1'b0;
      line_dirty_q[i] = 1'b0;
    end
    fifo_ptr = 0;
    stats = '0;
  endfunction

  function automatic cache_result_t predict_access(cache_cmd_e cmd, access_kind_e kind,
                                                   logic [ADDR_BITS-1:0] addr);
    cache_result_t        res;
    logic [ADDR_BITS-1:0] tag;
    int unsigned          lines;
    int unsigned          words;
    int unsigned          slot;
    bit                   found;
    res = '0;
    found = 1'b0;
    if (cmd == CMD_CLEAR) begin
      clear_store();
    end else begin
      tag = addr >> line_shift;
      lines = CACHE_WORDS >> line_shift;
      if (lines == 0) begin
        lines = 1;
      end
      words = 1 << line_shift;
      // Only the lowest matching line is touched when stale lines share a tag.
      for (int i = 0; i < lines && !found; i++) begin
        if (line_valid_q[i] && tag_store[i] == tag) begin
          found = 1'b1;
          if (kind == ACC_WRITE) begin
            line_dirty_q[i] = 1'b1;
          end
        end
      end
      if (found) begin
        if (kind == ACC_WRITE) begin
          stats[C_WH] = sat_add(stats[C_WH], 1);
        end else begin
          stats[C_RH] = sat_add(stats[C_RH], 1);
        end
      end else begin
        slot = (fifo_ptr < lines) ? fifo_ptr : 0;
        if (line_valid_q[slot] && line_dirty_q[slot]) begin
          res.dirty_evict = 1'b1;
          stats[C_WBACK] = sat_add(stats[C_WBACK], words);
        end
        tag_store[slot] = tag;
        line_valid_q[slot] = 1'b1;
        line_dirty_q[slot] = (kind == ACC_WRITE);
        stats[C_FETCH] = sat_add(stats[C_FETCH], words);
        if (kind == ACC_WRITE) begin
          stats[C_WM] = sat_add(stats[C_WM], 1);
        end else begin
          stats[C_RM] = sat_add(stats[C_RM], 1);
        end
        fifo_ptr = (slot + 1 >= lines) ? 0 : slot + 1;
      end
      res.hit = found;
    end
    res.counts = stats;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    if (mismatches < 200) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t want;
    if (rst) begin
      clear_store();
      line_shift = '0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_shift = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        expected_q.push_back(predict_access(cache_cmd_e'(s_tuser[0]),
                                            access_kind_e'(s_tuser[1]), s_addr));
      end
      if (m_tvalid && m_tready) begin
        got.hit = m_tuser[0];
        got.dirty_evict = m_tuser[1];
        got.counts = cnt_bank_t'(m_tdata);
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with no access pending", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit) begin
            report_mismatch("hit", got.hit, want.hit);
          end
          if (got.dirty_evict !== want.dirty_evict) begin
            report_mismatch("dirty_evict", got.dirty_evict, want.dirty_evict);
          end
          for (int k = 0; k < NUM_CNT; k++) begin
            if (got.counts[k] !== want.counts[k]) begin
              report_mismatch(cnt_names[k], got.counts[k], want.counts[k]);
            end
          end
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for fully_assoc_fifo_cache_tags_top: drives accesses, clears and line sizes.
// Depends on fac_pkg, the block itself and fac_tags_checker with fac_tb_pkg.
module testbench;
  import fac_pkg::*;
  import fac_tb_pkg::*;

  localparam int IN_W        = ((ADDR_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASE_ITEMS = 103;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_W-1:0]          s_tdata = '0;   // address
  logic [1:0]               s_tuser = '0;   // command, is_write
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [NUM_CNT*CNT_W-1:0] m_tdata;        // read_hits, read_misses, write_hits,
                                            // write_misses, words_fetched,
                                            // words_written_back
  logic [1:0]               m_tuser;        // hit, dirty_evict
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [LSZ_W-1:0]         cfg_data = '0;  // line_size_log2

  int          mismatches;
  int          outstanding;
  int unsigned cycles = 0;
  bit          gaps_on = 1'b1;
  int unsigned stall_left = 0;

  fully_assoc_fifo_cache_tags_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fac_tags_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_addr      (s_tdata[ADDR_BITS-1:0]),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // The receiver drops m_tready in random bursts while gaps are on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(cache_cmd_e cmd, access_kind_e kind, logic [ADDR_BITS-1:0] addr);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'(addr);
    s_tuser <= {kind, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_line_size(logic [LSZ_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [LSZ_W-1:0]     phase_shift [10] = '{0, 5, 7, 3, 1, 6, 2, 4, 7, 0};
    logic [ADDR_BITS-1:0] base;
    int unsigned          span;
    int unsigned          pick;
    access_kind_e         kind;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Basic hit, miss and clear behavior with one-word lines.
    send_item(CMD_ACCESS, ACC_READ, '0);
    send_item(CMD_ACCESS, ACC_READ, '0);
    send_item(CMD_ACCESS, ACC_WRITE, '0);
    send_item(CMD_ACCESS, ACC_WRITE, '1);
    send_item(CMD_ACCESS, ACC_READ, '1);
    send_item(CMD_CLEAR, ACC_WRITE, '1);
    send_item(CMD_ACCESS, ACC_READ, '0);

    // Two lines of 128 words: dirty and clean evictions in FIFO order.
    set_line_size(7);
    send_item(CMD_ACCESS, ACC_WRITE, 0);
    send_item(CMD_ACCESS, ACC_WRITE, 128);
    send_item(CMD_ACCESS, ACC_READ, 256);
    send_item(CMD_ACCESS, ACC_READ, 384);
    send_item(CMD_ACCESS, ACC_READ, 512);
    send_item(CMD_ACCESS, ACC_WRITE, 640);

    // Shrinking and growing the line count without a clear leaves stale lines
    // that can share a tag with a newer one.
    set_line_size(6);
    send_item(CMD_CLEAR, ACC_READ, 0);
    send_item(CMD_ACCESS, ACC_READ, 0);
    send_item(CMD_ACCESS, ACC_READ, 64);
    send_item(CMD_ACCESS, ACC_READ, 192);
    send_item(CMD_ACCESS, ACC_READ, 128);
    set_line_size(7);
    send_item(CMD_ACCESS, ACC_READ, 256);
    set_line_size(6);
    send_item(CMD_ACCESS, ACC_WRITE, 128);
    send_item(CMD_ACCESS, ACC_READ, 1024);
    send_item(CMD_ACCESS, ACC_READ, 2048);
    send_item(CMD_ACCESS, ACC_READ, 4096);
    send_item(CMD_ACCESS, ACC_READ, 8192);

    base = $urandom;
    for (int ph = 0; ph < 10; ph++) begin
      set_line_size(phase_shift[ph]);
      gaps_on = (ph != 4 && ph != 9);
      if ($urandom_range(0, 1) == 1) begin
        base = $urandom;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        kind = access_kind_e'($urandom_range(0, 1));
        span = ($urandom_range(0, 1) == 1) ? CACHE_WORDS : 2 * CACHE_WORDS;
        if (pick < 3) begin
          send_item(CMD_CLEAR, kind, $urandom);
        end else if (pick < 13) begin
          send_item(CMD_ACCESS, kind, $urandom);
        end else begin
          send_item(CMD_ACCESS, kind, base + $urandom_range(0, span - 1));
        end
      end
    end

    wait_idle();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/fac_pkg.sv
src/fac_ram.sv
src/fac_stats.sv
src/fully_assoc_fifo_cache_tags_top.sv
sim/fac_tags_checker.sv
sim/testbench.sv
